### hw/rtl/cdeq_pkg.sv
// cdeq_pkg: shared types and constants for the circular deque.
// Holds the request codes, the word structs of both channels and the FSM states.
// No dependencies.
`default_nettype none

package cdeq_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned CAP_W = 5;
    localparam int unsigned CAP_RESET = 16;
    localparam logic [VAL_W-1:0] EMPTY_MARK = '1;

    typedef enum logic [1:0] {
        REQ_INS_FRONT = 2'd0,
        REQ_INS_BACK  = 2'd1,
        REQ_DEL_FRONT = 2'd2,
        REQ_DEL_BACK  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type                req_type;
        logic signed [VAL_W-1:0]  item_value;
    } t_in_word;

    typedef struct packed {
        logic                     accepted;
        logic signed [VAL_W-1:0]  front_value;
        logic signed [VAL_W-1:0]  rear_value;
        logic                     now_empty;
        logic                     now_full;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_DONE = 2'd2
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/cdeq_ram.sv
// cdeq_ram: generic synchronous RAM, one write port and two read ports.
// Read data is registered and held while the read enable is low.
// No dependencies.
`default_nettype none

module cdeq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/circular_deque.sv
// circular_deque: ring-buffer double-ended queue over one slot RAM.
// States: IDLE accepts/updates, READ reads the slots, DONE captures the result.
// A new word is taken only in IDLE; DONE stalls until the result register is free.
// Reset (sync, active low): capacity = min(16, DEPTH), deque empty; slots stay unwritten.
// Depends on cdeq_pkg and cdeq_ram.
`default_nettype none

module circular_deque #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire cdeq_pkg::t_in_word   i_in_word,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output cdeq_pkg::t_out_word       o_out_word,
    // capacity register
    input  wire logic                 i_cap_we,
    input  wire logic [cdeq_pkg::CAP_W-1:0] i_cap_wdata
);

    import cdeq_pkg::*;

    // pointer and count widths
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    // ring state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_cap, n_cap;
    logic [PW-1:0]   r_fgp, n_fgp;     // free slot just before the front
    logic [PW-1:0]   r_bfp, n_bfp;     // free slot just after the rear
    logic [CW-1:0]   r_cnt, n_cnt;

    // per-word status carried from accept to capture
    logic            r_acc, n_acc;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out_word, n_out_word;

    // RAM port signals
    logic                ram_we;
    logic [PW-1:0]       ram_waddr;
    logic                ram_re;
    logic [PW-1:0]       rd_front_addr;
    logic [PW-1:0]       rd_rear_addr;
    logic [VAL_W-1:0]    rd_front;
    logic [VAL_W-1:0]    rd_rear;

    logic [CW-1:0]       cap_clamped;
    logic                in_fire;

    // step forward / backward around the ring of r_cap slots
    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p,
                                                input logic [CW-1:0] cap);
        logic [CW:0] inc;
        begin
            inc = (CW+1)'(p) + (CW+1)'(1);
            ring_next = (inc >= (CW+1)'(cap)) ? '0 : PW'(inc);
        end
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] last;
        begin
            last = cap - CW'(1);
            ring_prev = (p == '0) ? PW'(last) : p - PW'(1);
        end
    endfunction

    // capacity write: zero reads as one, anything above DEPTH as DEPTH
    always_comb begin
        if (i_cap_wdata == '0) begin
            cap_clamped = CW'(1);
        end else if (32'(i_cap_wdata) > 32'(DEPTH)) begin
            cap_clamped = CW'(DEPTH);
        end else begin
            cap_clamped = CW'(i_cap_wdata);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // read addresses come from the pointers already updated at accept,
    // so the RAM write of that edge is visible to this read
    assign rd_front_addr = ring_next(r_fgp, r_cap);
    assign rd_rear_addr  = ring_prev(r_bfp, r_cap);
    assign ram_re        = (r_state == ST_READ);

    cdeq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (i_in_word.item_value),
        .i_re      (ram_re),
        .i_raddr_a (rd_front_addr),
        .i_raddr_b (rd_rear_addr),
        .o_rdata_a (rd_front),
        .o_rdata_b (rd_rear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CW'(CAP_INIT);
            r_fgp       <= PW'(CAP_INIT - 1);
            r_bfp       <= '0;
            r_cnt       <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_fgp       <= n_fgp;
            r_bfp       <= n_bfp;
            r_cnt       <= n_cnt;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_fgp       = r_fgp;
        n_bfp       = r_bfp;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        ram_we      = 1'b0;
        ram_waddr   = r_bfp;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cap_we) begin
                    // new capacity empties the deque
                    n_cap = cap_clamped;
                    n_fgp = PW'(cap_clamped - CW'(1));
                    n_bfp = '0;
                    n_cnt = '0;
                end else if (in_fire) begin
                    n_acc = 1'b0;
                    case (i_in_word.req_type)
                        REQ_INS_FRONT: begin
                            if (r_cnt < r_cap) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_fgp;
                                n_fgp     = ring_prev(r_fgp, r_cap);
                                n_cnt     = r_cnt + CW'(1);
                                n_acc     = 1'b1;
                            end
                        end
                        REQ_INS_BACK: begin
                            if (r_cnt < r_cap) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_bfp;
                                n_bfp     = ring_next(r_bfp, r_cap);
                                n_cnt     = r_cnt + CW'(1);
                                n_acc     = 1'b1;
                            end
                        end
                        REQ_DEL_FRONT: begin
                            if (r_cnt != '0) begin
                                n_fgp = ring_next(r_fgp, r_cap);
                                n_cnt = r_cnt - CW'(1);
                                n_acc = 1'b1;
                            end
                        end
                        REQ_DEL_BACK: begin
                            if (r_cnt != '0) begin
                                n_bfp = ring_prev(r_bfp, r_cap);
                                n_cnt = r_cnt - CW'(1);
                                n_acc = 1'b1;
                            end
                        end
                        default: begin
                            n_acc = 1'b0;
                        end
                    endcase
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // front and rear slots are read this cycle
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // read data holds until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_word.accepted  = r_acc;
                    n_out_word.now_empty = (r_cnt == '0);
                    n_out_word.now_full  = (r_cnt == r_cap);
                    if (r_cnt == '0) begin
                        n_out_word.front_value = EMPTY_MARK;
                        n_out_word.rear_value  = EMPTY_MARK;
                    end else begin
                        n_out_word.front_value = rd_front;
                        n_out_word.rear_value  = rd_rear;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### tb/sv/circular_deque_tb.sv
// circular_deque_tb: self-checking testbench for the circular deque.
// Holds a shadow deque that predicts every result word, plus the drivers for both channels.
// Depends on cdeq_pkg and the circular_deque RTL.
`default_nettype none

module circular_deque_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdeq_pkg::*;

    localparam int unsigned RING_SLOTS  = 16;
    localparam int unsigned HOLD_CYCLES = 250;  // long receiver hold-off
    localparam int unsigned DRAIN_GAP   = 8;    // settle time after the last result, before a capacity write
    localparam int unsigned TAIL_GAP    = 12;   // quiet time at the end
    localparam int unsigned CYCLE_LIMIT = 200_000;

    // Shadow deque: mirrors capacity, pointers and slots, and queues the
    // result word each request taken on the channel must produce.
    class deque_shadow;
        logic [VAL_W-1:0] slots [RING_SLOTS];
        int unsigned      cap;
        int unsigned      gap_ptr;   // free slot just before the front
        int unsigned      free_ptr;  // free slot just after the rear
        int unsigned      count;
        t_out_word        due_words [$];
        int unsigned      fail_count;

        function new();
            foreach (slots[i]) slots[i] = '0;
            fail_count = 0;
            load_capacity(CAP_W'(CAP_RESET));
        endfunction

        function int unsigned step_fwd(int unsigned p);
            return (p + 1 >= cap) ? 0 : p + 1;
        endfunction

        function int unsigned step_back(int unsigned p);
            return (p == 0) ? cap - 1 : p - 1;
        endfunction

        // Write of the capacity register: clamp to 1..RING_SLOTS, empty the ring.
        function void load_capacity(logic [CAP_W-1:0] code);
            if (code == 0)
                cap = 1;
            else if (code > RING_SLOTS)
                cap = RING_SLOTS;
            else
                cap = int'(code);
            gap_ptr  = cap - 1;
            free_ptr = 0;
            count    = 0;
        endfunction

        function int unsigned pending();
            return due_words.size();
        endfunction

        function void log_fail(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void note_request(t_in_word w);
            t_out_word r;
            bit        done;
            done = 0;
            case (w.req_type)
                REQ_INS_FRONT: begin
                    if (count < cap) begin
                        slots[gap_ptr] = w.item_value;
                        gap_ptr = step_back(gap_ptr);
                        count++;
                        done = 1;
                    end
                end
                REQ_INS_BACK: begin
                    if (count < cap) begin
                        slots[free_ptr] = w.item_value;
                        free_ptr = step_fwd(free_ptr);
                        count++;
                        done = 1;
                    end
                end
                REQ_DEL_FRONT: begin
                    if (count != 0) begin
                        gap_ptr = step_fwd(gap_ptr);
                        count--;
                        done = 1;
                    end
                end
                default: begin
                    if (count != 0) begin
                        free_ptr = step_back(free_ptr);
                        count--;
                        done = 1;
                    end
                end
            endcase
            r.accepted    = done;
            r.front_value = (count != 0) ? slots[step_fwd(gap_ptr)] : EMPTY_MARK;
            r.rear_value  = (count != 0) ? slots[step_back(free_ptr)] : EMPTY_MARK;
            r.now_empty   = (count == 0);
            r.now_full    = (count == cap);
            due_words.insert(due_words.size(), r);
        endfunction

        function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (want !== got)
                log_fail($sformatf("%s expected %h, got %h", name, want, got));
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                log_fail($sformatf("unexpected result word %h", got));
                return;
            end
            want = due_words.pop_front();
            compare_field("accepted",    VAL_W'(want.accepted),  VAL_W'(got.accepted));
            compare_field("front_value", want.front_value,       got.front_value);
            compare_field("rear_value",  want.rear_value,        got.rear_value);
            compare_field("now_empty",   VAL_W'(want.now_empty), VAL_W'(got.now_empty));
            compare_field("now_full",    VAL_W'(want.now_full),  VAL_W'(got.now_full));
        endfunction

        function void close_out();
            if (due_words.size() != 0)
                log_fail($sformatf("%0d result words never arrived", due_words.size()));
        endfunction
    endclass

    // DUT-facing signals; the ones the bench drives are known from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cap_we    = 1'b0;
    logic [CAP_W-1:0]     i_cap_wdata = '0;

    deque_shadow shadow = new();

    // Idle knobs: percent of cycles the sender idles / the receiver stalls.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // Hold-off request: bumping hold_token starts a long stall, counted
    // down in the receiver process itself.
    int unsigned hold_token = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;

    int unsigned cycle_count = 0;

    circular_deque #(
        .DEPTH (RING_SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cap_we    (i_cap_we),
        .i_cap_wdata (i_cap_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: check the word taken at this edge, then pick next cycle's ready.
    // Everything read here is the pre-edge value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_word(o_out_word);
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one request word, with random idle cycles ahead of it, and hold
    // it until the block takes it. Returns at the accepting edge.
    task automatic send_req(input t_req_type op, input logic [VAL_W-1:0] val);
        t_in_word w;
        w.req_type   = op;
        w.item_value = val;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        shadow.note_request(w);
    endtask

    // Wait for the deque to go quiet, then write the capacity register.
    task automatic write_capacity(input logic [CAP_W-1:0] code);
        i_in_valid <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        i_cap_we    <= 1'b1;
        i_cap_wdata <= code;
        @(posedge i_clk);
        i_cap_we <= 1'b0;
        shadow.load_capacity(code);
    endtask

    // Corner values four times in ten, otherwise full 32-bit random.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // One random phase at a given capacity. Requests swing between a
    // fill-heavy and a drain-heavy mix so full and empty are both hit,
    // with some uniform noise on top.
    task automatic run_phase(input logic [CAP_W-1:0] cap_code, input int n_words,
                             input int idle_pct, input int stall_pct, input bit squeeze);
        bit        filling;
        int        roll;
        t_req_type op;
        write_capacity(cap_code);
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        filling = 1'b1;
        for (int k = 0; k < n_words; k++) begin
            if (squeeze && k == n_words / 4)
                hold_token <= hold_token + 1;
            if (shadow.count == shadow.cap)
                filling = 1'b0;
            else if (shadow.count == 0)
                filling = 1'b1;
            else if ($urandom_range(99) < 5)
                filling = ~filling;
            roll = $urandom_range(99);
            if (roll < 10)
                op = t_req_type'($urandom_range(3));
            else if ((roll < 75) == filling)
                op = $urandom_range(1) ? REQ_INS_BACK : REQ_INS_FRONT;
            else
                op = $urandom_range(1) ? REQ_DEL_BACK : REQ_DEL_FRONT;
            send_req(op, pick_value());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset capacity 16, deletes on empty, extreme values at both ends.
        send_req(REQ_DEL_FRONT, 32'h1234_5678);
        send_req(REQ_DEL_BACK,  32'h8765_4321);
        send_req(REQ_INS_FRONT, 32'h7FFF_FFFF);
        send_req(REQ_INS_BACK,  32'h8000_0000);
        send_req(REQ_INS_FRONT, 32'hFFFF_FFFF);
        send_req(REQ_INS_BACK,  32'h0000_0000);
        send_req(REQ_DEL_FRONT, 32'h0);
        send_req(REQ_DEL_BACK,  32'h0);
        send_req(REQ_DEL_FRONT, 32'h0);
        send_req(REQ_DEL_BACK,  32'h0);
        send_req(REQ_DEL_FRONT, 32'h0);          // refused: empty
        send_req(REQ_INS_BACK,  32'h0000_0001);  // single entry: front == rear
        send_req(REQ_DEL_FRONT, 32'h0);

        // Capacity 1: one insert fills it, further inserts refused.
        write_capacity(5'd1);
        send_req(REQ_INS_FRONT, 32'h5A5A_5A5A);
        send_req(REQ_INS_BACK,  32'hA5A5_A5A5);  // refused: full
        send_req(REQ_INS_FRONT, 32'h0F0F_0F0F);  // refused: full
        send_req(REQ_DEL_BACK,  32'h0);
        send_req(REQ_DEL_BACK,  32'h0);          // refused: empty
        send_req(REQ_INS_BACK,  32'hC3C3_C3C3);
        send_req(REQ_DEL_FRONT, 32'h0);

        // Capacity 2: the front pointer wraps.
        write_capacity(5'd2);
        send_req(REQ_INS_BACK,  32'h1111_1111);
        send_req(REQ_INS_FRONT, 32'h2222_2222);
        send_req(REQ_INS_BACK,  32'h3333_3333);  // refused: full
        send_req(REQ_DEL_FRONT, 32'h0);
        send_req(REQ_DEL_FRONT, 32'h0);

        // Random phases; 0 and values above 16 exercise the clamp.
        run_phase(5'd16, 150, 0,  0,  1'b1);
        run_phase(5'd1,  80,  46, 0,  1'b0);
        run_phase(5'd31, 120, 0,  46, 1'b0);
        run_phase(5'd3,  100, 23, 23, 1'b0);
        run_phase(5'd0,  60,  0,  0,  1'b0);
        run_phase(5'd5,  100, 46, 0,  1'b0);
        run_phase(5'd2,  80,  0,  46, 1'b0);
        run_phase(5'd17, 100, 23, 23, 1'b1);
        run_phase(CAP_W'($urandom_range(1, 16)), 80, 0, 0, 1'b0);
        run_phase(5'd8,  80,  23, 23, 1'b0);

        // Drain and let the pipeline go quiet.
        i_in_valid <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_GAP) @(posedge i_clk);
        shadow.close_out();

        if (shadow.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
